// File: hw/rtl/segment_intersection_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for segment_intersection
// Concurrent checks against clk and rst, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH
`ifndef SYNTHESIS
`define SI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("segment_intersection check failed");
`define SI_ASSERT_NEVER(lbl, cond) `SI_ASSERT(lbl, !(cond))
`else
`define SI_ASSERT(lbl, prop)
`define SI_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/si_pkg.sv
// ----------------------------------------------------------------------------
// si_pkg
// Widths, beat types and queue depths shared by the segment intersection.
// ----------------------------------------------------------------------------
package si_pkg;

  localparam int CW = 16;          // coordinate width
  localparam int DW = CW + 1;      // coordinate difference
  localparam int PW = 2 * DW;      // product of two differences
  localparam int NW = PW + 1;      // denominator and numerators, signed
  localparam int MW = NW - 1;      // magnitudes of denominator and numerator

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic                 parallel_flag;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } out_t;

  typedef struct packed {
    logic                 hit;
    logic                 par;
    logic        [MW-1:0] num;
    logic        [MW-1:0] den;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [DW-1:0] dxa;
    logic signed [DW-1:0] dya;
  } mid_t;

endpackage

// File: hw/rtl/si_fifo.sv
// ----------------------------------------------------------------------------
// si_fifo
// Small synchronous queue with registered count, first word fall through.
// ----------------------------------------------------------------------------
module si_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/si_front.sv
// ----------------------------------------------------------------------------
// si_front
// Differences, cross products and classification; three register stages.
// ----------------------------------------------------------------------------
module si_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  si_pkg::in_t   item,
  output logic          full,
  output logic          mid_push,
  output si_pkg::mid_t  mid_data,
  input  logic          mid_full
);

  localparam int CW = si_pkg::CW;
  localparam int DW = si_pkg::DW;
  localparam int PW = si_pkg::PW;
  localparam int NW = si_pkg::NW;
  localparam int MW = si_pkg::MW;

  logic adv;
  logic v1, v2, v3;

  logic signed [CW-1:0] x1_1, y1_1, x1_2, y1_2, x1_3, y1_3;
  logic signed [DW-1:0] dxa_1, dya_1, dxb_1, dyb_1, ox_1, oy_1;
  logic signed [DW-1:0] dxa_2, dya_2, dxa_3, dya_3;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [NW-1:0] den, na, nb;
  logic signed [NW-1:0] dm, nam, nbm;

  assign adv      = !v3 || !mid_full;
  assign full     = !adv;
  assign mid_push = v3 && !mid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_1  <= item.a_start_x;
      y1_1  <= item.a_start_y;
      dxa_1 <= {item.a_end_x[CW-1], item.a_end_x} - {item.a_start_x[CW-1], item.a_start_x};
      dya_1 <= {item.a_end_y[CW-1], item.a_end_y} - {item.a_start_y[CW-1], item.a_start_y};
      dxb_1 <= {item.b_end_x[CW-1], item.b_end_x} - {item.b_start_x[CW-1], item.b_start_x};
      dyb_1 <= {item.b_end_y[CW-1], item.b_end_y} - {item.b_start_y[CW-1], item.b_start_y};
      ox_1  <= {item.a_start_x[CW-1], item.a_start_x} - {item.b_start_x[CW-1], item.b_start_x};
      oy_1  <= {item.a_start_y[CW-1], item.a_start_y} - {item.b_start_y[CW-1], item.b_start_y};

      x1_2  <= x1_1;
      y1_2  <= y1_1;
      dxa_2 <= dxa_1;
      dya_2 <= dya_1;
      p0    <= dyb_1 * dxa_1;
      p1    <= dxb_1 * dya_1;
      p2    <= dxb_1 * oy_1;
      p3    <= dyb_1 * ox_1;
      p4    <= dxa_1 * oy_1;
      p5    <= dya_1 * ox_1;

      x1_3  <= x1_2;
      y1_3  <= y1_2;
      dxa_3 <= dxa_2;
      dya_3 <= dya_2;
      den   <= NW'(p0) - NW'(p1);
      na    <= NW'(p2) - NW'(p3);
      nb    <= NW'(p4) - NW'(p5);
    end
  end

  always_comb begin
    dm  = den[NW-1] ? -den : den;
    nam = den[NW-1] ? -na  : na;
    nbm = den[NW-1] ? -nb  : nb;
    mid_data.par = (den == '0);
    mid_data.hit = (den != '0) && !nam[NW-1] && (nam <= dm) && !nbm[NW-1] && (nbm <= dm);
    mid_data.num = nam[MW-1:0];
    mid_data.den = dm[MW-1:0];
    mid_data.x1  = x1_3;
    mid_data.y1  = y1_3;
    mid_data.dxa = dxa_3;
    mid_data.dya = dya_3;
  end

endmodule

// File: hw/rtl/si_back.sv
// ----------------------------------------------------------------------------
// si_back
// Interpolation by a pipelined shift-add divider, one stage per delta bit.
// ----------------------------------------------------------------------------
module si_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          mid_empty,
  input  si_pkg::mid_t  mid_data,
  output logic          mid_pop,
  output logic          out_push,
  output si_pkg::out_t  out_data,
  input  logic          out_full
);

  localparam int CW = si_pkg::CW;
  localparam int DW = si_pkg::DW;
  localparam int MW = si_pkg::MW;

  typedef struct packed {
    logic                 neg;
    logic        [DW-1:0] mag;
    logic signed [CW-1:0] base;
    logic        [DW-1:0] q;
    logic        [MW-1:0] r;
  } ax_t;

  typedef struct packed {
    logic          hit;
    logic          par;
    logic [MW-1:0] num;
    logic [MW-1:0] den;
    ax_t           x;
    ax_t           y;
  } bk_t;

  function automatic ax_t step_ax(ax_t a, logic [MW-1:0] num, logic [MW-1:0] den, logic b);
    ax_t           o;
    logic [MW-1:0] r2;
    logic [DW-1:0] q2;
    o  = a;
    r2 = {a.r[MW-2:0], 1'b0};
    q2 = {a.q[DW-2:0], 1'b0};
    if (r2 >= den) begin
      r2 = r2 - den;
      q2 = q2 + 1'b1;
    end
    if (b) begin
      r2 = r2 + num;
      if (r2 >= den) begin
        r2 = r2 - den;
        q2 = q2 + 1'b1;
      end
    end
    o.r = r2;
    o.q = q2;
    return o;
  endfunction

  function automatic logic [CW-1:0] finish_ax(ax_t a);
    logic signed [DW:0] w;
    w = a.neg ? {a.base[CW-1], a.base[CW-1], a.base} - {1'b0, a.q}
              : {a.base[CW-1], a.base[CW-1], a.base} + {1'b0, a.q};
    if (a.r != '0) begin
      if (!a.neg && w[DW]) begin
        w = w + 1'b1;
      end else if (a.neg && !w[DW] && (w != '0)) begin
        w = w - 1'b1;
      end
    end
    return w[CW-1:0];
  endfunction

  logic adv;
  logic vld [DW+1];
  bk_t  st  [DW+1];
  bk_t  ld;

  assign adv      = !vld[DW] || !out_full;
  assign mid_pop  = adv && !mid_empty;
  assign out_push = vld[DW] && !out_full;

  always_comb begin
    ld.hit    = mid_data.hit;
    ld.par    = mid_data.par;
    ld.num    = mid_data.hit ? mid_data.num : '0;
    ld.den    = mid_data.den;
    ld.x.neg  = mid_data.dxa[DW-1];
    ld.x.mag  = mid_data.dxa[DW-1] ? -mid_data.dxa : mid_data.dxa;
    ld.x.base = mid_data.x1;
    ld.x.q    = '0;
    ld.x.r    = '0;
    ld.y.neg  = mid_data.dya[DW-1];
    ld.y.mag  = mid_data.dya[DW-1] ? -mid_data.dya : mid_data.dya;
    ld.y.base = mid_data.y1;
    ld.y.q    = '0;
    ld.y.r    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= !mid_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= ld;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1].hit <= st[k].hit;
        st[k+1].par <= st[k].par;
        st[k+1].num <= st[k].num;
        st[k+1].den <= st[k].den;
        st[k+1].x   <= step_ax(st[k].x, st[k].num, st[k].den, st[k].x.mag[DW-1-k]);
        st[k+1].y   <= step_ax(st[k].y, st[k].num, st[k].den, st[k].y.mag[DW-1-k]);
      end
    end
  end

  always_comb begin
    out_data.hit           = st[DW].hit;
    out_data.parallel_flag = st[DW].par;
    out_data.cross_x       = st[DW].hit ? finish_ax(st[DW].x) : '0;
    out_data.cross_y       = st[DW].hit ? finish_ax(st[DW].y) : '0;
  end

endmodule

// File: hw/rtl/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// Parametric intersection test of two integer line segments.
//
//   channel   handshake         beat
//   item      push / full       si_pkg::in_t   (two segments)
//   result    pop / empty       si_pkg::out_t  (hit, parallel, point)
//
// One beat per cycle in and out while neither queue is full. The path from accept
// to a visible result is 3 front stages, one write into the classify queue, a load
// stage and CW+1 divider steps (one per delta bit), then one write into the result queue.
// Reset clears valid bits and queue pointers and counts only. Each side stalls on its own
// queue: full rises when the classify queue fills with a beat held at the front.
// ----------------------------------------------------------------------------
`include "segment_intersection_defines.svh"

module segment_intersection #(
  parameter int MID_DEPTH = si_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = si_pkg::OUT_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  si_pkg::in_t   item,
  output logic          full,
  input  logic          pop,
  output si_pkg::out_t  result,
  output logic          empty
);

  logic         mid_push, mid_full, mid_pop, mid_empty;
  si_pkg::mid_t mid_wdata, mid_rdata;
  logic         out_push, out_full;
  si_pkg::out_t out_wdata;

  si_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .mid_push (mid_push),
    .mid_data (mid_wdata),
    .mid_full (mid_full)
  );

  si_fifo #(
    .WIDTH ($bits(si_pkg::mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  si_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_push  (out_push),
    .out_data  (out_wdata),
    .out_full  (out_full)
  );

  si_fifo #(
    .WIDTH ($bits(si_pkg::out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  `SI_ASSERT_NEVER(a_hit_parallel, !empty && result.hit && result.parallel_flag)
  `SI_ASSERT(a_miss_zero, (!empty && !result.hit) |-> (result.cross_x == '0 && result.cross_y == '0))

endmodule

// File: tb/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_test
// Drives segment pairs into the intersection block and checks every result
// beat against an exact integer prediction of hit, parallel and crossing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_test;

  localparam int CW = si_pkg::CW;

  class crossing_board;
    si_pkg::out_t pending[$];
    int           errors;
    int           checked;

    function automatic longint exact_trunc(longint n, longint d);
      return n / d;
    endfunction

    function automatic si_pkg::out_t solve_pair(si_pkg::in_t p);
      longint x1, y1, x2, y2, x3, y3, x4, y4;
      longint dxa, dya, dxb, dyb, ox, oy, den, na, nb;
      si_pkg::out_t r;
      x1 = p.a_start_x; y1 = p.a_start_y; x2 = p.a_end_x; y2 = p.a_end_y;
      x3 = p.b_start_x; y3 = p.b_start_y; x4 = p.b_end_x; y4 = p.b_end_y;
      dxa = x2 - x1; dya = y2 - y1; dxb = x4 - x3; dyb = y4 - y3;
      ox = x1 - x3; oy = y1 - y3;
      den = dyb * dxa - dxb * dya;
      na = dxb * oy - dyb * ox;
      nb = dxa * oy - dya * ox;
      r = '0;
      if (den == 0) begin
        r.parallel_flag = 1'b1;
      end else begin
        if (den < 0) begin
          den = -den; na = -na; nb = -nb;
        end
        if (na >= 0 && na <= den && nb >= 0 && nb <= den) begin
          r.hit = 1'b1;
          r.cross_x = CW'(exact_trunc(x1 * den + dxa * na, den));
          r.cross_y = CW'(exact_trunc(y1 * den + dya * na, den));
        end
      end
      return r;
    endfunction

    function void note_pair(si_pkg::in_t p);
      pending.push_back(solve_pair(p));
    endfunction

    function void check_result(si_pkg::out_t got);
      si_pkg::out_t exp;
      checked++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, got.hit); errors++;
      end
      if (got.parallel_flag !== exp.parallel_flag) begin
        $error("parallel_flag: expected %0d, got %0d", exp.parallel_flag,
               got.parallel_flag); errors++;
      end
      if (got.cross_x !== exp.cross_x) begin
        $error("cross_x: expected %0d, got %0d", exp.cross_x, got.cross_x); errors++;
      end
      if (got.cross_y !== exp.cross_y) begin
        $error("cross_y: expected %0d, got %0d", exp.cross_y, got.cross_y); errors++;
      end
    endfunction
  endclass

  localparam int LIMIT = 200000;
  localparam int DRAIN = 3 * CW + 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  si_pkg::in_t  item = '0;
  si_pkg::out_t result;

  crossing_board board = new();
  int   hits, parallels, cycles;
  bit   drain_pop = 1'b0;

  segment_intersection i_dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .pop(pop), .result(result), .empty(empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst && pop && !empty) begin
      if (result.hit) hits++;
      if (result.parallel_flag) parallels++;
      board.check_result(result);
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern: long open runs mixed with choppy stalls
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (drain_pop) begin
      pop <= 1'b1;
    end else begin
      case ((cycles / 64) % 4)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= cycles[2];
      endcase
    end
  end

  task automatic send_pair(si_pkg::in_t p);
    item <= p;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_pair(p);
    @(negedge clk);
  endtask

  task automatic pause_line(int n);
    push <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] small_coord();
    return CW'(int'($urandom_range(0, 64)) - 32);
  endfunction

  function automatic si_pkg::in_t random_pair();
    si_pkg::in_t p;
    int  kind;
    logic signed [CW-1:0] c;
    kind = $urandom_range(0, 9);
    p.a_start_x = CW'($urandom);
    p.a_start_y = CW'($urandom);
    p.a_end_x = CW'($urandom);
    p.a_end_y = CW'($urandom);
    p.b_start_x = CW'($urandom);
    p.b_start_y = CW'($urandom);
    p.b_end_x = CW'($urandom);
    p.b_end_y = CW'($urandom);
    if (kind < 4) begin
      // small coordinates give many crossings
      p.a_start_x = small_coord();
      p.a_start_y = small_coord();
      p.a_end_x = small_coord();
      p.a_end_y = small_coord();
      p.b_start_x = small_coord();
      p.b_start_y = small_coord();
      p.b_end_x = small_coord();
      p.b_end_y = small_coord();
    end else if (kind < 7) begin
      // crossing by construction: diagonals of a random box
      p.b_start_x = p.a_start_x;
      p.b_end_x = p.a_end_x;
      p.b_start_y = p.a_end_y;
      p.b_end_y = p.a_start_y;
    end else if (kind == 7) begin
      // parallel: B is A shifted
      c = CW'($urandom);
      p.b_start_x = p.a_start_x;
      p.b_end_x = p.a_end_x;
      p.b_start_y = p.a_start_y ^ c;
      p.b_end_y = p.b_start_y + (p.a_end_y - p.a_start_y);
    end
    return p;
  endfunction

  initial begin
    si_pkg::in_t p;
    int  burst;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    p = '0;
    send_pair(p);
    // plain X crossing
    p = '{-10, -10, 10, 10, -10, 10, 10, -10}; send_pair(p);
    // touching at endpoints: parameters 0 and 1
    p = '{0, 0, 10, 0, 0, 0, 0, 10}; send_pair(p);
    p = '{0, 0, 10, 0, 10, -5, 10, 5}; send_pair(p);
    // miss, parallel, collinear
    p = '{0, 0, 10, 0, 20, -5, 20, 5}; send_pair(p);
    p = '{0, 0, 10, 0, 0, 3, 10, 3}; send_pair(p);
    p = '{0, 0, 10, 0, 5, 0, 15, 0}; send_pair(p);
    // negative point that truncates toward zero
    p = '{-7, 0, 0, 3, -7, 3, 0, 0}; send_pair(p);
    p = '{0, -1, 3, 0, 0, 0, 3, -1}; send_pair(p);
    // extremes
    p = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}; send_pair(p);
    p = '{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}; send_pair(p);
    p = '{-32768, 0, 32767, 0, 0, -32768, 0, 32767}; send_pair(p);
    p = '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767}; send_pair(p);
    p = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_pair(p);
    p = '{-32768, -32767, 32767, 32766, 1, -32768, -2, 32767}; send_pair(p);
    p = '1; send_pair(p);

    // hold until every expected beat has drained
    push <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);

    for (int n = 0; n < 400;) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < 400; k++, n++) send_pair(random_pair());
      if ($urandom_range(0, 3) != 0) pause_line($urandom_range(1, 12));
      if (n > 200 && n < 230) begin
        push <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
      end
    end
    push <= 1'b0;
    drain_pop = 1'b1;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("checked %0d result beats: %0d crossings, %0d parallel", board.checked,
             hits, parallels);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/si_pkg.sv
hw/rtl/si_fifo.sv
hw/rtl/si_front.sv
hw/rtl/si_back.sv
hw/rtl/segment_intersection.sv
tb/segment_intersection_test.sv
